@@ sv/qlgdbf_pkg.sv @@
// shared types and constants of the qc-ldpc gdbf bit-flip decoder
// no dependencies; imported by the top level, the sequencer and the datapath
`default_nettype none

package qlgdbf_pkg;

  // default sizes of the code
  localparam int CIRCULANT_SIZE_DEF = 32;
  localparam int MAX_BASE_ROWS_DEF  = 8;
  localparam int MAX_BASE_COLS_DEF  = 32;

  // fixed field widths
  localparam int ROW_W    = 3;
  localparam int COL_W    = 5;
  localparam int SHIFT_W  = 6;
  localparam int BLOCK_W  = 32;
  localparam int IDX_W    = 5;
  localparam int ITER_W   = 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_ROWS_W = 4;
  localparam int CFG_COLS_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 2'd2;

  localparam logic [CFG_ROWS_W-1:0] RST_BASE_ROWS = 4'd3;
  localparam logic [CFG_COLS_W-1:0] RST_BASE_COLS = 6'd5;
  localparam logic [ITER_W-1:0]     RST_MAX_ITER  = 8'd100;

  // datapath operations, one column (or lane) per command
  typedef enum logic [3:0] {
    OP_NOP,
    OP_COPY,
    OP_EINIT,
    OP_PAR,
    OP_EUPD,
    OP_MAX,
    OP_RED,
    OP_FLIP,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   first;
    logic   last;
    logic   recv_we;
    logic   shift_we;
  } dp_cmd_t;

  typedef struct packed {
    logic unsat;
    logic out_valid;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ sv/qc_ldpc_gdbf_bit_flip_decoder.sv @@
// top level of the hard-decision gdbf decoder for quasi-cyclic ldpc codes
// depends on qlgdbf_pkg, qlgdbf_ctrl, qlgdbf_dp (and qlgdbf_ram below it)
//
// Items on the input channel either write one shift entry of the base matrix
// (operation 0) or deliver one received column block (operation 1); the block
// flagged last_block starts a decode of base_cols_used blocks. While a frame
// decodes, in_stall stays high. One column step is done per cycle by a single
// shared column unit, with a drain state after every pass. A frame starts with
// a copy pass; each iteration then runs an energy-init pass, a parity and an
// energy-update pass per base row, a maximum pass, a lane reduction and a flip
// pass. A converged iteration ends after its parity and energy-update passes.
// Results follow in column order with the converged flag and the iteration
// count, one at a time and held while the receiver stalls; out_last marks the
// final one. The shift table needs no clearing pass: its entries carry valid
// bits cleared at reset.
`default_nettype none

module qc_ldpc_gdbf_bit_flip_decoder #(
  parameter int CIRCULANT_SIZE = qlgdbf_pkg::CIRCULANT_SIZE_DEF,
  parameter int MAX_BASE_ROWS  = qlgdbf_pkg::MAX_BASE_ROWS_DEF,
  parameter int MAX_BASE_COLS  = qlgdbf_pkg::MAX_BASE_COLS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // configuration writes
  input  wire logic                                  cfg_write_en,
  input  wire logic [qlgdbf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [qlgdbf_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  in_operation,
  input  wire logic [qlgdbf_pkg::ROW_W-1:0]           in_base_row,
  input  wire logic [qlgdbf_pkg::COL_W-1:0]           in_base_col,
  input  wire logic signed [qlgdbf_pkg::SHIFT_W-1:0]  in_shift_value,
  input  wire logic [qlgdbf_pkg::BLOCK_W-1:0]         in_block_bits,
  input  wire logic                                  in_last_block,
  // result channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [qlgdbf_pkg::IDX_W-1:0]                out_block_index,
  output logic [qlgdbf_pkg::BLOCK_W-1:0]              out_decoded_bits,
  output logic                                       out_converged,
  output logic [qlgdbf_pkg::ITER_W-1:0]               out_iterations_used,
  output logic                                       out_last
);

  import qlgdbf_pkg::*;

  localparam int CIW = $clog2(MAX_BASE_COLS);
  localparam int RIW = (MAX_BASE_ROWS > 1) ? $clog2(MAX_BASE_ROWS) : 1;

  // command and status between sequencer and datapath
  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [CIW-1:0]    col;
  logic [RIW-1:0]    row;
  logic              conv;
  logic [ITER_W-1:0] used;

  qlgdbf_ctrl #(
    .CIRCULANT_SIZE (CIRCULANT_SIZE),
    .MAX_BASE_ROWS  (MAX_BASE_ROWS),
    .MAX_BASE_COLS  (MAX_BASE_COLS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_last_block (in_last_block),
    .out_stall     (out_stall),
    .stat          (stat),
    .cmd           (cmd),
    .col           (col),
    .row           (row),
    .conv          (conv),
    .used          (used)
  );

  // datapath: all stores, rotations, energy lanes and the result register
  qlgdbf_dp #(
    .CIRCULANT_SIZE (CIRCULANT_SIZE),
    .MAX_BASE_ROWS  (MAX_BASE_ROWS),
    .MAX_BASE_COLS  (MAX_BASE_COLS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .col                 (col),
    .row                 (row),
    .conv                (conv),
    .used                (used),
    .in_base_row         (in_base_row),
    .in_base_col         (in_base_col),
    .in_shift_value      (in_shift_value),
    .in_block_bits       (in_block_bits),
    .out_stall           (out_stall),
    .stat                (stat),
    .out_valid           (out_valid),
    .out_block_index     (out_block_index),
    .out_decoded_bits    (out_decoded_bits),
    .out_converged       (out_converged),
    .out_iterations_used (out_iterations_used),
    .out_last            (out_last)
  );

endmodule

`default_nettype wire

@@ sv/qlgdbf_ram.sv @@
// generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module qlgdbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/qlgdbf_ctrl.sv @@
// sequencer of the gdbf decoder: config registers, frame loading, iteration control
// depends on qlgdbf_pkg
`default_nettype none

module qlgdbf_ctrl #(
  parameter int CIRCULANT_SIZE = qlgdbf_pkg::CIRCULANT_SIZE_DEF,
  parameter int MAX_BASE_ROWS  = qlgdbf_pkg::MAX_BASE_ROWS_DEF,
  parameter int MAX_BASE_COLS  = qlgdbf_pkg::MAX_BASE_COLS_DEF,
  localparam int CIW = $clog2(MAX_BASE_COLS),
  localparam int RIW = (MAX_BASE_ROWS > 1) ? $clog2(MAX_BASE_ROWS) : 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_write_en,
  input  wire logic [qlgdbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [qlgdbf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_operation,
  input  wire logic                             in_last_block,
  input  wire logic                             out_stall,
  input  wire qlgdbf_pkg::dp_stat_t              stat,
  output qlgdbf_pkg::dp_cmd_t                   cmd,
  output logic [CIW-1:0]                        col,
  output logic [RIW-1:0]                        row,
  output logic                                  conv,
  output logic [qlgdbf_pkg::ITER_W-1:0]          used
);

  import qlgdbf_pkg::*;

  localparam int COL_LIMIT = (MAX_BASE_COLS < 32) ? MAX_BASE_COLS : 32;
  localparam int CEW = $clog2(COL_LIMIT + 1);
  localparam int REW = $clog2(MAX_BASE_ROWS + 1);
  localparam int LW  = $clog2(CIRCULANT_SIZE);

  typedef enum logic [3:0] {
    S_IDLE,
    S_COPY,
    S_EINIT,
    S_PAR,
    S_EUPD,
    S_MAX,
    S_RED,
    S_FLIP,
    S_DRAIN,
    S_EMIT,
    S_EMIT_W
  } state_t;

  state_t                 state_r, state_nxt, ret_r, ret_nxt;
  logic [CIW-1:0]         col_r, col_nxt;
  logic [RIW-1:0]         row_r, row_nxt;
  logic [LW-1:0]          lane_r, lane_nxt;
  logic [ITER_W-1:0]      iter_r, iter_nxt;
  logic [CEW-1:0]         blk_r, blk_nxt;
  logic                   conv_r, conv_nxt;
  logic [ITER_W-1:0]      used_r, used_nxt;
  logic [CFG_ROWS_W-1:0]  rows_cfg_r;
  logic [CFG_COLS_W-1:0]  cols_cfg_r;
  logic [ITER_W-1:0]      maxit_cfg_r;

  logic [REW-1:0]    rows_eff;
  logic [CEW-1:0]    cols_eff;
  logic [ITER_W-1:0] maxit_eff;
  logic              col_last, row_last, lane_last, iter_done, in_acc;

  // register values outside their range saturate
  always_comb begin
    if (rows_cfg_r == '0) begin
      rows_eff = REW'(1);
    end else if (32'(rows_cfg_r) > MAX_BASE_ROWS) begin
      rows_eff = REW'(MAX_BASE_ROWS);
    end else begin
      rows_eff = REW'(rows_cfg_r);
    end
    if (cols_cfg_r == '0) begin
      cols_eff = CEW'(1);
    end else if (32'(cols_cfg_r) > COL_LIMIT) begin
      cols_eff = CEW'(COL_LIMIT);
    end else begin
      cols_eff = CEW'(cols_cfg_r);
    end
    maxit_eff = (maxit_cfg_r == '0) ? ITER_W'(1) : maxit_cfg_r;
  end

  assign col_last  = (32'(col_r) + 1 == 32'(cols_eff));
  assign row_last  = (32'(row_r) + 1 == 32'(rows_eff));
  assign lane_last = (32'(lane_r) + 1 == CIRCULANT_SIZE);
  assign iter_done = ((ITER_W + 1)'(iter_r) + 1'b1 == (ITER_W + 1)'(maxit_eff));
  assign in_acc    = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    lane_nxt  = lane_r;
    iter_nxt  = iter_r;
    blk_nxt   = blk_r;
    conv_nxt  = conv_r;
    used_nxt  = used_r;
    cmd       = '0;
    cmd.op    = OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_operation) begin
            cmd.shift_we = 1'b1;
          end else begin
            if (blk_r < cols_eff) begin
              cmd.recv_we = 1'b1;
              blk_nxt     = blk_r + 1'b1;
            end
            if (in_last_block) begin
              blk_nxt   = '0;
              col_nxt   = '0;
              state_nxt = S_COPY;
            end
          end
        end
      end
      S_COPY: begin
        cmd.op = OP_COPY;
        if (col_last) begin
          col_nxt   = '0;
          iter_nxt  = '0;
          ret_nxt   = S_EINIT;
          state_nxt = S_DRAIN;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      S_EINIT: begin
        cmd.op = OP_EINIT;
        if (col_last) begin
          col_nxt   = '0;
          row_nxt   = '0;
          ret_nxt   = S_PAR;
          state_nxt = S_DRAIN;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      S_PAR: begin
        cmd.op    = OP_PAR;
        cmd.first = (col_r == '0);
        cmd.last  = col_last;
        if (col_last) begin
          col_nxt   = '0;
          ret_nxt   = S_EUPD;
          state_nxt = S_DRAIN;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      S_EUPD: begin
        cmd.op = OP_EUPD;
        if (col_last) begin
          col_nxt   = '0;
          state_nxt = S_DRAIN;
          if (row_last) begin
            if (!stat.unsat) begin
              conv_nxt = 1'b1;
              used_nxt = iter_r + 1'b1;
              ret_nxt  = S_EMIT;
            end else begin
              ret_nxt = S_MAX;
            end
          end else begin
            row_nxt = row_r + 1'b1;
            ret_nxt = S_PAR;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      S_MAX: begin
        cmd.op    = OP_MAX;
        cmd.first = (col_r == '0);
        if (col_last) begin
          col_nxt   = '0;
          lane_nxt  = '0;
          ret_nxt   = S_RED;
          state_nxt = S_DRAIN;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      S_RED: begin
        cmd.op    = OP_RED;
        cmd.first = (lane_r == '0);
        if (lane_last) begin
          lane_nxt  = '0;
          ret_nxt   = S_FLIP;
          state_nxt = S_DRAIN;
        end else begin
          lane_nxt = lane_r + 1'b1;
        end
      end
      S_FLIP: begin
        cmd.op = OP_FLIP;
        if (col_last) begin
          col_nxt   = '0;
          state_nxt = S_DRAIN;
          if (iter_done) begin
            conv_nxt = 1'b0;
            used_nxt = maxit_eff;
            ret_nxt  = S_EMIT;
          end else begin
            iter_nxt = iter_r + 1'b1;
            ret_nxt  = S_EINIT;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = ret_r;
      end
      S_EMIT: begin
        if (!stat.out_valid || !out_stall) begin
          cmd.op    = OP_EMIT;
          cmd.last  = col_last;
          state_nxt = S_EMIT_W;
        end
      end
      S_EMIT_W: begin
        if (col_last) begin
          col_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          col_nxt   = col_r + 1'b1;
          state_nxt = S_EMIT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      lane_r      <= '0;
      iter_r      <= '0;
      blk_r       <= '0;
      conv_r      <= 1'b0;
      used_r      <= '0;
      rows_cfg_r  <= RST_BASE_ROWS;
      cols_cfg_r  <= RST_BASE_COLS;
      maxit_cfg_r <= RST_MAX_ITER;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      lane_r  <= lane_nxt;
      iter_r  <= iter_nxt;
      blk_r   <= blk_nxt;
      conv_r  <= conv_nxt;
      used_r  <= used_nxt;
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_BASE_ROWS: rows_cfg_r  <= cfg_data[CFG_ROWS_W-1:0];
          CFG_BASE_COLS: cols_cfg_r  <= cfg_data[CFG_COLS_W-1:0];
          CFG_MAX_ITER:  maxit_cfg_r <= cfg_data[ITER_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign col      = (state_r == S_IDLE) ? blk_r[CIW-1:0] : col_r;
  assign row      = row_r;
  assign conv     = conv_r;
  assign used     = used_r;

endmodule

`default_nettype wire

@@ sv/qlgdbf_dp.sv @@
// datapath of the gdbf decoder: shift table, bit and energy stores, parity and flip logic
// depends on qlgdbf_pkg and qlgdbf_ram
`default_nettype none

module qlgdbf_dp #(
  parameter int CIRCULANT_SIZE = qlgdbf_pkg::CIRCULANT_SIZE_DEF,
  parameter int MAX_BASE_ROWS  = qlgdbf_pkg::MAX_BASE_ROWS_DEF,
  parameter int MAX_BASE_COLS  = qlgdbf_pkg::MAX_BASE_COLS_DEF,
  localparam int CIW = $clog2(MAX_BASE_COLS),
  localparam int RIW = (MAX_BASE_ROWS > 1) ? $clog2(MAX_BASE_ROWS) : 1
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire qlgdbf_pkg::dp_cmd_t                  cmd,
  input  wire logic [CIW-1:0]                      col,
  input  wire logic [RIW-1:0]                      row,
  input  wire logic                                conv,
  input  wire logic [qlgdbf_pkg::ITER_W-1:0]        used,
  input  wire logic [qlgdbf_pkg::ROW_W-1:0]         in_base_row,
  input  wire logic [qlgdbf_pkg::COL_W-1:0]         in_base_col,
  input  wire logic signed [qlgdbf_pkg::SHIFT_W-1:0] in_shift_value,
  input  wire logic [qlgdbf_pkg::BLOCK_W-1:0]       in_block_bits,
  input  wire logic                                out_stall,
  output qlgdbf_pkg::dp_stat_t                     stat,
  output logic                                     out_valid,
  output logic [qlgdbf_pkg::IDX_W-1:0]              out_block_index,
  output logic [qlgdbf_pkg::BLOCK_W-1:0]            out_decoded_bits,
  output logic                                     out_converged,
  output logic [qlgdbf_pkg::ITER_W-1:0]             out_iterations_used,
  output logic                                     out_last
);

  import qlgdbf_pkg::*;

  localparam int Z      = CIRCULANT_SIZE;
  localparam int ZW     = $clog2(Z);
  localparam int SDEPTH = MAX_BASE_ROWS * MAX_BASE_COLS;
  localparam int SAW    = $clog2(SDEPTH);
  localparam int SEW    = ZW + 1;
  localparam int EW     = $clog2(MAX_BASE_ROWS + 2) + 1;

  // shift amounts reduced modulo the circulant size, fixed at elaboration
  logic [ZW-1:0] mod_lut [32];
  for (genvar i = 0; i < 32; i++) begin : g_mod
    assign mod_lut[i] = ZW'(i % CIRCULANT_SIZE);
  end

  dp_cmd_t        cmd_q;
  logic [CIW-1:0] col_q;

  // shift table with reset-cleared valid bits
  logic             sh_vld_r [SDEPTH];
  logic             sh_vld_q;
  logic             sh_we;
  logic [SAW-1:0]   sh_waddr, sh_raddr;
  logic [SEW-1:0]   sh_wdata, sh_q;

  assign sh_we    = cmd.shift_we && (32'(in_base_row) < MAX_BASE_ROWS)
                    && (32'(in_base_col) < MAX_BASE_COLS);
  assign sh_waddr = SAW'(32'(in_base_row) * MAX_BASE_COLS + 32'(in_base_col));
  assign sh_raddr = SAW'(32'(row) * MAX_BASE_COLS + 32'(col));
  assign sh_wdata = {in_shift_value[SHIFT_W-1], mod_lut[in_shift_value[4:0]]};

  qlgdbf_ram #(.WIDTH(SEW), .DEPTH(SDEPTH)) u_shift (
    .clk   (clk),
    .we    (sh_we),
    .waddr (sh_waddr),
    .wdata (sh_wdata),
    .raddr (sh_raddr),
    .rdata (sh_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SDEPTH; i++) begin
        sh_vld_r[i] <= 1'b0;
      end
    end else if (sh_we) begin
      sh_vld_r[sh_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    sh_vld_q <= sh_vld_r[sh_raddr];
  end

  // received and decision stores
  logic [Z+BLOCK_W-1:0] in_ext;
  logic [Z-1:0]         rcv_q, dec_q, dec_wdata, flipped;
  logic                 dec_we;

  assign in_ext = {{Z{1'b0}}, in_block_bits};

  qlgdbf_ram #(.WIDTH(Z), .DEPTH(MAX_BASE_COLS)) u_recv (
    .clk   (clk),
    .we    (cmd.recv_we),
    .waddr (col),
    .wdata (in_ext[Z-1:0]),
    .raddr (col),
    .rdata (rcv_q)
  );

  assign dec_we    = (cmd_q.op == OP_COPY) || (cmd_q.op == OP_FLIP);
  assign dec_wdata = (cmd_q.op == OP_COPY) ? rcv_q : flipped;

  qlgdbf_ram #(.WIDTH(Z), .DEPTH(MAX_BASE_COLS)) u_dec (
    .clk   (clk),
    .we    (dec_we),
    .waddr (col_q),
    .wdata (dec_wdata),
    .raddr (col),
    .rdata (dec_q)
  );

  // energy store, one column block of lanes per word
  logic [Z*EW-1:0] e_q, e_wdata, e_init, e_upd;
  logic            e_we;

  qlgdbf_ram #(.WIDTH(Z*EW), .DEPTH(MAX_BASE_COLS)) u_energy (
    .clk   (clk),
    .we    (e_we),
    .waddr (col_q),
    .wdata (e_wdata),
    .raddr (col),
    .rdata (e_q)
  );

  // column step
  logic                 absent;
  logic [ZW-1:0]        k;
  logic [2*Z-1:0]       dec_dbl, cn_dbl;
  logic [Z-1:0]         term, back, cn_nxt, flip_mask;
  logic [Z-1:0]         cn_r;
  logic                 unsat_r, unsat_nxt;
  logic signed [EW-1:0] e_lane [Z];
  logic signed [EW-1:0] lm_r [Z];
  logic signed [EW-1:0] lm_nxt [Z];
  logic signed [EW-1:0] emax_r, emax_nxt;

  assign absent  = !sh_vld_q || sh_q[ZW];
  assign k       = sh_q[ZW-1:0];
  assign dec_dbl = {dec_q, dec_q} >> k;
  assign cn_dbl  = {cn_r, cn_r} << k;
  assign term    = absent ? '0 : dec_dbl[Z-1:0];
  assign back    = cn_dbl[2*Z-1:Z];
  assign cn_nxt  = (cmd_q.first ? '0 : cn_r) ^ term;

  always_comb begin
    for (int b = 0; b < Z; b++) begin
      e_lane[b]            = e_q[b*EW +: EW];
      e_init[b*EW +: EW]   = (dec_q[b] ^ rcv_q[b]) ? EW'(1) : {EW{1'b1}};
      e_upd[b*EW +: EW]    = e_q[b*EW +: EW] + (back[b] ? EW'(1) : {EW{1'b1}});
      flip_mask[b]         = (e_lane[b] == emax_r);
    end
  end

  assign flipped = dec_q ^ flip_mask;
  assign e_we    = (cmd_q.op == OP_EINIT) || ((cmd_q.op == OP_EUPD) && !absent);
  assign e_wdata = (cmd_q.op == OP_EINIT) ? e_init : e_upd;

  always_comb begin
    unsat_nxt = unsat_r;
    emax_nxt  = emax_r;
    for (int b = 0; b < Z; b++) begin
      lm_nxt[b] = lm_r[b];
    end
    case (cmd_q.op)
      OP_EINIT: begin
        unsat_nxt = 1'b0;
      end
      OP_PAR: begin
        if (cmd_q.last && (cn_nxt != '0)) begin
          unsat_nxt = 1'b1;
        end
      end
      OP_MAX: begin
        for (int b = 0; b < Z; b++) begin
          if (cmd_q.first || (e_lane[b] > lm_r[b])) begin
            lm_nxt[b] = e_lane[b];
          end
        end
      end
      OP_RED: begin
        // rotate the lane maxima past lane zero
        for (int b = 0; b < Z; b++) begin
          lm_nxt[b] = lm_r[(b + 1) % Z];
        end
        if (cmd_q.first || (lm_r[0] > emax_r)) begin
          emax_nxt = lm_r[0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_q   <= '0;
      unsat_r <= 1'b0;
      cn_r    <= '0;
    end else begin
      cmd_q   <= cmd;
      unsat_r <= unsat_nxt;
      if (cmd_q.op == OP_PAR) begin
        cn_r <= cn_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    col_q  <= col;
    emax_r <= emax_nxt;
    for (int b = 0; b < Z; b++) begin
      lm_r[b] <= lm_nxt[b];
    end
  end

  // result register
  logic [Z+BLOCK_W-1:0] out_ext;
  logic                 out_valid_r;

  assign out_ext = {{BLOCK_W{1'b0}}, dec_q};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_q.op == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_q.op == OP_EMIT) begin
      out_block_index     <= IDX_W'(col_q);
      out_decoded_bits    <= out_ext[BLOCK_W-1:0];
      out_converged       <= conv;
      out_iterations_used <= used;
      out_last            <= cmd_q.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign stat.unsat     = unsat_r;
  assign stat.out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ sv/qlgdbf_chk.sv @@
// port-level checker of the gdbf decoder, attached to the top level by bind
// depends on qc_ldpc_gdbf_bit_flip_decoder
`default_nettype none

module qlgdbf_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_operation,
  input wire logic        in_last_block,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [4:0]  out_block_index,
  input wire logic [31:0] out_decoded_bits,
  input wire logic        out_last
);

  // a final block transfer starts a decode, which holds off input
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_operation && in_last_block |=> in_stall)
    else $error("input taken right after a final block");

  // results other than the final one only appear while a frame is in progress
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("non-final result pending while input is open");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_decoded_bits)
      && $stable(out_block_index))
    else $error("stalled result changed");

endmodule

bind qc_ldpc_gdbf_bit_flip_decoder qlgdbf_chk u_chk (.*);

`default_nettype wire

@@ dv/qc_ldpc_gdbf_bit_flip_decoder_tb.sv @@
// self-checking testbench of the qc-ldpc gdbf bit-flip decoder
// depends on qlgdbf_pkg and qc_ldpc_gdbf_bit_flip_decoder; runs standalone
`timescale 1ns / 1ps

module qc_ldpc_gdbf_bit_flip_decoder_tb;
  import qlgdbf_pkg::*;

  // input item kinds
  localparam logic ITEM_SHIFT_WR = 1'b0;
  localparam logic ITEM_BLOCK    = 1'b1;
  localparam int   Z             = 32;

  typedef struct {
    logic               op;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic signed [SHIFT_W-1:0] shift;
    logic [BLOCK_W-1:0] bits;
    logic               last;
  } item_t;

  typedef struct {
    logic [IDX_W-1:0]   idx;
    logic [BLOCK_W-1:0] bits;
    logic               conv;
    logic [ITER_W-1:0]  iters;
    logic               last;
  } block_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_operation = 1'b0;
  logic [ROW_W-1:0] in_base_row = '0;
  logic [COL_W-1:0] in_base_col = '0;
  logic signed [SHIFT_W-1:0] in_shift_value = '0;
  logic [BLOCK_W-1:0] in_block_bits = '0;
  logic in_last_block = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IDX_W-1:0] out_block_index;
  logic [BLOCK_W-1:0] out_decoded_bits;
  logic out_converged;
  logic [ITER_W-1:0] out_iterations_used;
  logic out_last;

  qc_ldpc_gdbf_bit_flip_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_base_row(in_base_row), .in_base_col(in_base_col),
    .in_shift_value(in_shift_value), .in_block_bits(in_block_bits),
    .in_last_block(in_last_block),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_block_index(out_block_index), .out_decoded_bits(out_decoded_bits),
    .out_converged(out_converged), .out_iterations_used(out_iterations_used),
    .out_last(out_last)
  );

  always #10 clk = ~clk;

  // pending transfers and expected decoded blocks
  item_t      pending_items[$];
  block_res_t expected_blocks[$];
  int         fail_cnt = 0;
  int         n_items = 0;
  bit         no_gaps = 1'b0;

  // decoder mirror: shift table, stores and registers
  int         shift_tab[8][32];
  logic [31:0] recv_words[32];
  logic [31:0] dec_words[32];
  bit         written[32];
  int         blk_cnt = 0;
  int         reg_rows = RST_BASE_ROWS;
  int         reg_cols = RST_BASE_COLS;
  int         reg_maxit = RST_MAX_ITER;

  function automatic int clamp_reg(int v, int hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // bit i of the result is bit (i + s) mod Z of x
  function automatic logic [31:0] rot_dn(logic [31:0] x, int s);
    if (s == 0) return x;
    return (x >> s) | (x << (Z - s));
  endfunction

  // full gdbf decode of the frame, queues one expected block per column
  task automatic run_gdbf();
    int rows, cols, maxit, used, emax, k;
    bit conv, unsat;
    logic [31:0] cn, back, d;
    int eng[32][32];
    block_res_t res;
    rows = clamp_reg(reg_rows, 8);
    cols = clamp_reg(reg_cols, 32);
    maxit = clamp_reg(reg_maxit, 255);
    used = maxit;
    conv = 1'b0;
    for (int c = 0; c < cols; c++) dec_words[c] = recv_words[c];
    for (int it = 0; it < maxit; it++) begin
      unsat = 1'b0;
      emax = -255;
      for (int c = 0; c < cols; c++) begin
        d = dec_words[c] ^ recv_words[c];
        for (int b = 0; b < Z; b++) eng[c][b] = d[b] ? 1 : -1;
      end
      for (int r = 0; r < rows; r++) begin
        cn = '0;
        for (int c = 0; c < cols; c++)
          if (shift_tab[r][c] >= 0) cn ^= rot_dn(dec_words[c], shift_tab[r][c]);
        if (cn != 0) unsat = 1'b1;
        for (int c = 0; c < cols; c++) begin
          if (shift_tab[r][c] >= 0) begin
            k = shift_tab[r][c];
            back = rot_dn(cn, (Z - k) % Z);
            for (int b = 0; b < Z; b++) eng[c][b] += back[b] ? 1 : -1;
          end
        end
      end
      if (!unsat) begin
        conv = 1'b1;
        used = it + 1;
        break;
      end
      for (int c = 0; c < cols; c++)
        for (int b = 0; b < Z; b++)
          if (eng[c][b] > emax) emax = eng[c][b];
      for (int c = 0; c < cols; c++)
        for (int b = 0; b < Z; b++)
          if (eng[c][b] == emax) dec_words[c][b] = ~dec_words[c][b];
    end
    for (int c = 0; c < cols; c++) begin
      res.idx = IDX_W'(c);
      res.bits = dec_words[c];
      res.conv = conv;
      res.iters = ITER_W'(used);
      res.last = (c == cols - 1);
      expected_blocks.push_back(res);
    end
  endtask

  // mirror of one accepted input transfer
  task automatic predict_item(item_t it);
    int cols;
    if (it.op == ITEM_SHIFT_WR) begin
      shift_tab[it.row][it.col] = (it.shift < 0) ? -1 : int'(it.shift);
    end else begin
      cols = clamp_reg(reg_cols, 32);
      if (blk_cnt < cols) begin
        recv_words[blk_cnt] = it.bits;
        blk_cnt++;
      end
      if (it.last) begin
        blk_cnt = 0;
        run_gdbf();
      end
    end
  endtask

  task automatic report_mismatch(string what, longint exp_v, longint got_v);
    $display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $time);
    fail_cnt++;
  endtask

  function automatic int draw_wait();
    return no_gaps ? 0 : $urandom_range(0, 13);
  endfunction

  // driver: one transfer per item, random gap after each
  int gap_cnt = 0;
  item_t cur_item;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (in_valid && !in_stall) predict_item(cur_item);
      if (in_valid && in_stall) begin
        // payload holds while stalled
      end else if (gap_cnt > 0) begin
        in_valid <= 1'b0;
        gap_cnt <= gap_cnt - 1;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        in_valid <= 1'b1;
        in_operation <= cur_item.op;
        in_base_row <= cur_item.row;
        in_base_col <= cur_item.col;
        in_shift_value <= cur_item.shift;
        in_block_bits <= cur_item.bits;
        in_last_block <= cur_item.last;
        gap_cnt <= draw_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each decoded block, stalls a random time after each
  int stall_cnt = 0;
  block_res_t exp_blk;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch("unexpected block_index", 0, out_block_index);
        end else begin
          exp_blk = expected_blocks.pop_front();
          if (out_block_index !== exp_blk.idx)
            report_mismatch("block_index", exp_blk.idx, out_block_index);
          if (out_decoded_bits !== exp_blk.bits)
            report_mismatch("decoded_bits", exp_blk.bits, out_decoded_bits);
          if (out_converged !== exp_blk.conv)
            report_mismatch("converged", exp_blk.conv, out_converged);
          if (out_iterations_used !== exp_blk.iters)
            report_mismatch("iterations_used", exp_blk.iters, out_iterations_used);
          if (out_last !== exp_blk.last)
            report_mismatch("last", exp_blk.last, out_last);
        end
      end
      if (stall_cnt > 0) begin
        out_stall <= 1'b1;
        stall_cnt <= stall_cnt - 1;
      end else begin
        out_stall <= 1'b0;
        if (out_valid && !out_stall) stall_cnt <= draw_wait();
      end
    end
  end

  task automatic push_shift(int row, int col, int val);
    item_t it;
    it.op = ITEM_SHIFT_WR;
    it.row = ROW_W'(row);
    it.col = COL_W'(col);
    it.shift = SHIFT_W'(val);
    it.bits = $urandom();
    it.last = 1'($urandom_range(0, 1));
    pending_items.push_back(it);
    n_items++;
  endtask

  task automatic push_block(logic [31:0] w, logic lst, bit counted);
    item_t it;
    it.op = ITEM_BLOCK;
    it.row = ROW_W'($urandom_range(0, 7));
    it.col = COL_W'($urandom_range(0, 31));
    it.shift = SHIFT_W'($urandom_range(0, 63));
    it.bits = w;
    it.last = lst;
    pending_items.push_back(it);
    if (counted) n_items++;
  endtask

  // mode 0 random, 1 near all-zero codeword, 2 all ones
  function automatic logic [31:0] make_word(int mode);
    logic [31:0] w;
    case (mode)
      0: w = $urandom();
      1: begin
        w = '0;
        if ($urandom_range(0, 3) == 0) w[5'($urandom_range(0, 31))] = 1'b1;
      end
      default: w = '1;
    endcase
    return w;
  endfunction

  // n blocks of the frame, then extra ones dropped by the decoder
  task automatic send_frame(int n, int extra, int mode);
    int cols;
    cols = clamp_reg(reg_cols, 32);
    for (int i = 0; i < n + extra; i++) begin
      push_block(make_word(mode), i == n + extra - 1, i < cols);
      if (i < cols) written[i] = 1'b1;
    end
  endtask

  function automatic bit short_ok(int n);
    for (int c = n; c < clamp_reg(reg_cols, 32); c++)
      if (!written[c]) return 1'b0;
    return 1'b1;
  endfunction

  // waits until every transfer is taken and every block has come back
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_blocks.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      CFG_BASE_ROWS: reg_rows = val & 'hF;
      CFG_BASE_COLS: reg_cols = val & 'h3F;
      default:       reg_maxit = val & 'hFF;
    endcase
  endtask

  task automatic set_regs(int rows, int cols, int maxit);
    write_reg(CFG_BASE_ROWS, rows);
    write_reg(CFG_BASE_COLS, cols);
    write_reg(CFG_MAX_ITER, maxit);
  endtask

  // random shift entries inside the used part of the base matrix
  task automatic rand_shifts(int cnt);
    int rows, cols;
    rows = clamp_reg(reg_rows, 8);
    cols = clamp_reg(reg_cols, 32);
    for (int i = 0; i < cnt; i++)
      push_shift($urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                 ($urandom_range(0, 3) == 0) ? -$urandom_range(1, 32) : $urandom_range(0, 31));
  endtask

  initial begin
    int cols, n, kind;
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 32; c++) shift_tab[r][c] = -1;
    for (int c = 0; c < 32; c++) written[c] = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers, empty table: every check trivially satisfied
    push_block('0, 1'b0, 1'b1);
    push_block('1, 1'b0, 1'b1);
    push_block(32'h8000_0001, 1'b0, 1'b1);
    push_block(32'h5555_aaaa, 1'b0, 1'b1);
    push_block(32'h0000_0001, 1'b1, 1'b1);
    for (int c = 0; c < 5; c++) written[c] = 1'b1;
    // zero, top, absent, most negative and ordinary shifts; one entry outside use
    push_shift(0, 0, 0);
    push_shift(0, 1, 31);
    push_shift(0, 2, -1);
    push_shift(0, 3, -32);
    push_shift(0, 4, 5);
    push_shift(1, 0, 1);
    push_shift(1, 2, 7);
    push_shift(1, 4, 30);
    push_shift(2, 1, 12);
    push_shift(2, 3, 3);
    push_shift(7, 31, 17);
    send_frame(5, 0, 1);
    send_frame(5, 2, 0);   // extra blocks dropped
    send_frame(2, 0, 2);   // short frame keeps the older columns
    wait_idle();

    // register extremes, saturation both ways
    set_regs(8'hFF, 63, 2);
    rand_shifts(20);
    send_frame(32, 0, 1);
    wait_idle();
    set_regs(0, 0, 0);
    send_frame(1, 0, 0);
    send_frame(1, 1, 1);
    wait_idle();
    set_regs(8, 1, 255);
    rand_shifts(6);
    send_frame(1, 0, 0);
    wait_idle();

    // random phases, mostly small frames, now and then a wide one
    while (n_items < 310) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0)
        set_regs($urandom_range(1, 8), $urandom_range(9, 32), $urandom_range(1, 4));
      else
        set_regs($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 16));
      cols = clamp_reg(reg_cols, 32);
      rand_shifts($urandom_range(2, 12));
      repeat ($urandom_range(2, 4)) begin
        kind = $urandom_range(0, 19);
        n = (cols > 1) ? $urandom_range(1, cols - 1) : 1;
        if (kind < 3) send_frame(cols, $urandom_range(1, 3), $urandom_range(0, 2));
        else if (kind < 6 && cols > 1 && short_ok(n)) send_frame(n, 0, $urandom_range(0, 1));
        else send_frame(cols, 0, ($urandom_range(0, 2) == 0) ? 0 : 1);
      end
      wait_idle();
    end

    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
